### src/bpmq_pkg.sv
// ----------------------------------------------------------------------------
// bpmq_pkg
// Shared codes, field widths and control types for the buffer pool and
// message queue block.
// ----------------------------------------------------------------------------
`default_nettype none

package bpmq_pkg;

   // Field widths of one request and one response
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 6;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 7;

   // Packed stream widths, padded to whole bytes
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_OBTAIN  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEND    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RECEIVE = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_POOL_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUE_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 2'd3;

   // Where the response index comes from
   localparam logic [1:0] SRC_NONE  = 2'd0;
   localparam logic [1:0] SRC_FREE  = 2'd1;
   localparam logic [1:0] SRC_QUEUE = 2'd2;

   // Push and pop strobes for one ring
   typedef struct packed {
      logic push;
      logic pop;
   } ring_ctrl_type;

endpackage

`default_nettype wire

### src/bpmq_ring.sv
// ----------------------------------------------------------------------------
// bpmq_ring
// Circular list of buffer indices held in one synchronous memory. Push
// writes at the write pointer, pop reads at the read pointer with the read
// data registered. With INIT_IDENTITY set the list starts full, entry i
// holding index i; entries not yet overwritten since reset read as their
// own position, tracked by the write pointer and a wrap flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bpmq_ring
   import bpmq_pkg::*;
#(
   parameter int DEPTH         = 64,
   parameter bit INIT_IDENTITY = 1'b0,
   parameter int LW            = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ring_ctrl_type    ctrl,
   input  wire logic [IDX_W-1:0] push_data,
   output logic      [LW-1:0]    level,
   output logic                  empty,
   output logic                  full,
   output logic      [IDX_W-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);

   logic [IDX_W-1:0] mem [DEPTH];
   logic [IDX_W-1:0] rd_ff;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [LW-1:0]    level_ff, level_in;

   // Advance pointers with wrap, track fill level
   always_comb begin
      rptr_in  = rptr_ff;
      wptr_in  = wptr_ff;
      level_in = level_ff;
      if (ctrl.pop) begin
         rptr_in  = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         level_in = level_ff - 1'b1;
      end
      if (ctrl.push) begin
         wptr_in  = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         level_in = level_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rptr_ff  <= '0;
         wptr_ff  <= '0;
         level_ff <= INIT_IDENTITY ? LW'(DEPTH) : '0;
      end else begin
         rptr_ff  <= rptr_in;
         wptr_ff  <= wptr_in;
         level_ff <= level_in;
      end
   end

   // Write on push, registered read on pop
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wptr_ff] <= push_data;
      end
      if (ctrl.pop) begin
         rd_ff <= mem[rptr_ff];
      end
   end

   generate
      if (INIT_IDENTITY) begin : g_identity
         logic                wrapped_ff;
         logic                init_sel_ff;
         logic [IDX_W-1:0]    init_val_ff;
         logic [PW+IDX_W-1:0] rptr_ext;

         assign rptr_ext = {{IDX_W{1'b0}}, rptr_ff};

         // Mark once every entry has been overwritten
         always_ff @(posedge clock) begin
            if (reset) begin
               wrapped_ff <= 1'b0;
            end else if (ctrl.push && wptr_ff == PW'(DEPTH - 1)) begin
               wrapped_ff <= 1'b1;
            end
         end

         // Entry never overwritten reads as its own position
         always_ff @(posedge clock) begin
            if (ctrl.pop) begin
               init_sel_ff <= !(wrapped_ff || rptr_ff < wptr_ff);
               init_val_ff <= rptr_ext[IDX_W-1:0];
            end
         end

         assign pop_data = init_sel_ff ? init_val_ff : rd_ff;
      end else begin : g_plain
         assign pop_data = rd_ff;
      end
   endgenerate

   assign level = level_ff;
   assign empty = (level_ff == '0);
   assign full  = (level_ff == LW'(DEPTH));

endmodule

`default_nettype wire

### src/buffer_pool_message_queue.sv
// ----------------------------------------------------------------------------
// buffer_pool_message_queue
// Buffer pool with a FIFO free list and a circular message queue. Obtain
// and release work on the free list, send and receive on the queue.
//
//   channel   dir   fields (low bit first)
//   req_*     in    command[1:0], buffer_index[7:2]
//   rsp_*     out   status[1:0], result_index[7:2], free_count[14:8],
//                   queued_count[21:15]
//
// One request per cycle when no response is stalled. A request is handled
// in the cycle it is accepted; its response is valid the next cycle,
// after the registered read of the free-list or queue memory.
// A new request is taken while a response is taken in the same cycle;
// a stalled response holds the request side.
// Reset is synchronous; the free list starts full in ascending order with
// no clearing pass, the queue starts empty.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_message_queue
   import bpmq_pkg::*;
#(
   parameter int POOL_DEPTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // command, buffer_index
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata   // status, result_index,
                                                  // free_count, queued_count
);

   localparam int LW = $clog2(POOL_DEPTH + 1);

   logic              accept;
   logic [CMD_W-1:0]  cmd;
   logic [IDX_W-1:0]  idx;
   logic              free_empty, free_full, q_empty, q_full;
   logic [LW-1:0]     free_level, q_level;
   logic [IDX_W-1:0]  free_data, q_data;
   ring_ctrl_type     free_ctrl, q_ctrl;
   logic [STATUS_W-1:0] status_in;
   logic [1:0]        src_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [1:0]          src_ff;
   logic [IDX_W-1:0]    result_index;
   logic [LW+CNT_W-1:0] free_ext, q_ext;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign cmd        = req_tdata[CMD_W-1:0];
   assign idx        = req_tdata[CMD_W+IDX_W-1:CMD_W];

   // Decode command, check levels, drive ring strobes
   always_comb begin
      status_in = ST_OK;
      src_in    = SRC_NONE;
      free_ctrl = '0;
      q_ctrl    = '0;
      unique case (cmd)
         CMD_OBTAIN: begin
            if (free_empty) begin
               status_in = ST_POOL_EMPTY;
            end else begin
               src_in         = SRC_FREE;
               free_ctrl.pop  = accept;
            end
         end
         CMD_RELEASE: begin
            if (free_full) begin
               status_in = ST_OVERFLOW;
            end else begin
               free_ctrl.push = accept;
            end
         end
         CMD_SEND: begin
            if (q_full) begin
               status_in = ST_OVERFLOW;
            end else begin
               q_ctrl.push = accept;
            end
         end
         CMD_RECEIVE: begin
            if (q_empty) begin
               status_in = ST_QUEUE_EMPTY;
            end else begin
               src_in     = SRC_QUEUE;
               q_ctrl.pop = accept;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   bpmq_ring #(
      .DEPTH         (POOL_DEPTH),
      .INIT_IDENTITY (1'b1),
      .LW            (LW)
   ) u_free (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (free_ctrl),
      .push_data (idx),
      .level     (free_level),
      .empty     (free_empty),
      .full      (free_full),
      .pop_data  (free_data)
   );

   bpmq_ring #(
      .DEPTH         (POOL_DEPTH),
      .INIT_IDENTITY (1'b0),
      .LW            (LW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (q_ctrl),
      .push_data (idx),
      .level     (q_level),
      .empty     (q_empty),
      .full      (q_full),
      .pop_data  (q_data)
   );

   // Hold the response until taken, reload on each accepted request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         src_ff    <= src_in;
      end
   end

   // Select the popped index; ring levels change only with a new response
   always_comb begin
      case (src_ff)
         SRC_FREE:  result_index = free_data;
         SRC_QUEUE: result_index = q_data;
         default:   result_index = '0;
      endcase
   end

   assign free_ext   = {{CNT_W{1'b0}}, free_level};
   assign q_ext      = {{CNT_W{1'b0}}, q_level};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, q_ext[CNT_W-1:0], free_ext[CNT_W-1:0],
                        result_index, status_ff};

   // Obtain from an empty pool reports pool empty
   a_pool_empty: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == CMD_OBTAIN && free_empty |=> status_ff == ST_POOL_EMPTY)
      else $error("obtain from empty pool not reported");

   // A successful obtain takes exactly one buffer from the pool
   a_obtain_level: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == CMD_OBTAIN && !free_empty
      |=> free_level == $past(free_level) - 1'b1)
      else $error("free level not decremented on obtain");

   // Levels never exceed the pool depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      free_level <= LW'(POOL_DEPTH) && q_level <= LW'(POOL_DEPTH))
      else $error("ring level beyond pool depth");

   // An index is returned only with status ok
   a_src_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && src_ff != SRC_NONE |-> status_ff == ST_OK)
      else $error("index returned with error status");

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buffer pool and message queue. A driver feeds
// obtain, release, send and receive requests from a backlog filled up front.
// Each accepted request runs through a local copy of the free list and the
// message ring. A monitor compares every response, field by field, with the
// oldest prediction. Both sides idle at random, the receiver holds off once
// for a long stretch, and the sender pauses twice until all replies are in.
// ----------------------------------------------------------------------------
module tb
   import bpmq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 1150;
   localparam int HOLD_CYCLES  = 200;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      int unsigned      gap;    // idle cycles before this request
      bit               drain;  // hold until every reply has come back
   } pool_cmd_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index;
      logic [CNT_W-1:0]    free_cnt;
      logic [CNT_W-1:0]    queued_cnt;
   } pool_reply_type;

   typedef enum int {MODE_MIX, MODE_DRAIN_POOL, MODE_FILL_POOL,
                     MODE_FILL_QUEUE, MODE_DRAIN_QUEUE} burst_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // command, buffer_index
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // status, result_index,
                                            // free_count, queued_count

   pool_cmd_type   pending_cmds[$];
   pool_reply_type predicted_replies[$];
   int             cmd_total = 0;
   int             reply_count = 0;
   int             fail_count = 0;
   int unsigned    send_idle = 0;
   int unsigned    rsp_stall = 0;
   int unsigned    hold_left = 0;
   bit             hold_done = 1'b0;
   bit             rsp_calm = 1'b0;

   // Shadow of the pool state
   logic [IDX_W-1:0] free_ring[DEPTH];
   logic [IDX_W-1:0] msg_ring[DEPTH];
   logic [IDX_W-1:0] free_rd, free_wr, msg_rd, msg_wr;
   logic [CNT_W-1:0] free_lvl, msg_lvl;

   buffer_pool_message_queue #(.POOL_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Apply one command to the shadow pool and return its reply
   function automatic pool_reply_type pool_apply(logic [CMD_W-1:0] cmd,
                                                logic [IDX_W-1:0] idx);
      pool_reply_type r;
      r.status = ST_OK;
      r.index  = '0;
      case (cmd)
         CMD_OBTAIN: begin
            if (free_lvl == 0) begin
               r.status = ST_POOL_EMPTY;
            end else begin
               r.index = free_ring[free_rd];
               free_rd++;
               free_lvl--;
            end
         end
         CMD_RELEASE: begin
            if (free_lvl >= DEPTH) begin
               r.status = ST_OVERFLOW;
            end else begin
               free_ring[free_wr] = idx;
               free_wr++;
               free_lvl++;
            end
         end
         CMD_SEND: begin
            if (msg_lvl >= DEPTH) begin
               r.status = ST_OVERFLOW;
            end else begin
               msg_ring[msg_wr] = idx;
               msg_wr++;
               msg_lvl++;
            end
         end
         default: begin
            if (msg_lvl == 0) begin
               r.status = ST_QUEUE_EMPTY;
            end else begin
               r.index = msg_ring[msg_rd];
               msg_rd++;
               msg_lvl--;
            end
         end
      endcase
      r.free_cnt   = free_lvl;
      r.queued_cnt = msg_lvl;
      return r;
   endfunction

   task automatic add_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                          int unsigned gap, bit drain);
      pool_cmd_type c;
      c.cmd   = cmd;
      c.idx   = idx;
      c.gap   = gap;
      c.drain = drain;
      pending_cmds.push_back(c);
      cmd_total++;
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Drive requests; predict the reply of each one accepted
   always @(posedge clock) begin
      pool_cmd_type nxt;
      logic         offer;
      int unsigned  idle_n;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer  = req_tvalid;
         idle_n = send_idle;
         if (req_tvalid && req_tready) begin
            predicted_replies.push_back(pool_apply(req_tdata[1:0], req_tdata[7:2]));
            offer = 1'b0;
            if (pending_cmds.size() != 0) idle_n = pending_cmds[0].gap;
         end
         if (!offer && pending_cmds.size() != 0) begin
            if (idle_n != 0) begin
               idle_n--;
            end else if (!(pending_cmds[0].drain && predicted_replies.size() != 0)) begin
               nxt = pending_cmds.pop_front();
               req_tdata <= {nxt.idx, nxt.cmd};
               offer = 1'b1;
            end
         end
         send_idle  <= idle_n;
         req_tvalid <= offer;
      end
   end

   // Check responses against predictions; stall at random
   always @(posedge clock) begin
      pool_reply_type want;
      int unsigned    stall_n;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_n = rsp_stall;
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_replies.size() == 0) begin
               $display("%0t unexpected response: expected none actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = predicted_replies.pop_front();
               check_field("status", want.status, rsp_tdata[1:0]);
               check_field("result_index", want.index, rsp_tdata[7:2]);
               check_field("free_count", want.free_cnt, rsp_tdata[14:8]);
               check_field("queued_count", want.queued_cnt, rsp_tdata[21:15]);
            end
            reply_count <= reply_count + 1;
            stall_n = rsp_calm ? 0 : pick_gap();
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         end
         if (stall_n != 0) begin
            stall_n--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (hold_left == 0);
         end
         rsp_stall <= stall_n;
      end
   end

   // Hold off the receiver once while requests keep coming
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && reply_count >= 500 && req_tvalid) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   // Stop a hung run
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      burst_mode_type   mode;
      int               burst_len;
      bit               calm;
      int unsigned      r;
      logic [CMD_W-1:0] cmd;

      // Reset image of the shadow pool
      for (int i = 0; i < DEPTH; i++) begin
         free_ring[i] = i[IDX_W-1:0];
         msg_ring[i]  = '0;
      end
      free_rd  = '0;
      free_wr  = '0;
      msg_rd   = '0;
      msg_wr   = '0;
      free_lvl = CNT_W'(DEPTH);
      msg_lvl  = '0;

      // Directed: release to a full pool, receive from an empty queue,
      // index extremes, alternating bit patterns, ignored index fields
      add_cmd(CMD_RELEASE, 6'd63, 0, 1'b0);
      add_cmd(CMD_RELEASE, 6'd0, 0, 1'b0);
      add_cmd(CMD_RECEIVE, 6'd63, 0, 1'b0);
      add_cmd(CMD_OBTAIN, 6'd0, 0, 1'b0);
      add_cmd(CMD_OBTAIN, 6'd63, 1, 1'b0);
      add_cmd(CMD_SEND, 6'd63, 0, 1'b0);
      add_cmd(CMD_SEND, 6'd0, 0, 1'b0);
      add_cmd(CMD_SEND, 6'd42, 2, 1'b0);
      add_cmd(CMD_SEND, 6'd21, 0, 1'b0);
      add_cmd(CMD_RECEIVE, 6'd0, 0, 1'b0);
      add_cmd(CMD_RECEIVE, 6'd42, 0, 1'b0);
      add_cmd(CMD_RELEASE, 6'd63, 0, 1'b0);
      add_cmd(CMD_RELEASE, 6'd0, 3, 1'b0);
      add_cmd(CMD_RELEASE, 6'd5, 0, 1'b0);
      add_cmd(CMD_OBTAIN, 6'd21, 0, 1'b0);
      add_cmd(CMD_RECEIVE, 6'd0, 0, 1'b0);
      add_cmd(CMD_RECEIVE, 6'd0, 0, 1'b0);
      add_cmd(CMD_RECEIVE, 6'd0, 0, 1'b0);
      add_cmd(CMD_OBTAIN, 6'd0, 0, 1'b0);
      add_cmd(CMD_OBTAIN, 6'd63, 0, 1'b0);
      add_cmd(CMD_SEND, 6'd1, 0, 1'b1);

      // Random bursts biased to empty or fill the pool and the queue
      while (cmd_total < RANDOM_ITEMS) begin
         mode      = burst_mode_type'($urandom_range(0, 4));
         burst_len = $urandom_range(8, 90);
         calm      = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < burst_len && cmd_total < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 7);
            case (mode)
               MODE_DRAIN_POOL:  cmd = CMD_OBTAIN;
               MODE_FILL_POOL:   cmd = CMD_RELEASE;
               MODE_FILL_QUEUE:  cmd = CMD_SEND;
               MODE_DRAIN_QUEUE: cmd = CMD_RECEIVE;
               default:          r = 7;
            endcase
            if (r == 7) cmd = CMD_W'($urandom_range(0, 3));
            add_cmd(cmd, IDX_W'($urandom_range(0, 63)), calm ? 0 : pick_gap(),
                    (cmd_total == 600));
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (reply_count != cmd_total) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0 && predicted_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
